### rtl/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debouncer with long-press detect
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned PageW  = 3;
  localparam int unsigned CfgIdxW = 2;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LAST_PAGE = 2'd2;

  // reset values of the registers
  localparam logic [MsW-1:0]   DEBOUNCE_RST   = 16'd35;
  localparam logic [MsW-1:0]   LONG_PRESS_RST = 16'd1200;
  localparam logic [PageW-1:0] LAST_PAGE_RST  = 3'd4;

  typedef struct packed {
    logic [MsW-1:0]   debounce_ms;
    logic [MsW-1:0]   long_press_ms;
    logic [PageW-1:0] last_page;
  } cfg_t;

  typedef struct packed {
    logic             stable_level;
    logic [PageW-1:0] page;
    logic             portrait_mode;
    logic             page_stepped;
    logic             rotated;
  } res_t;

endpackage

### rtl/bdlp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_cfg_regs
// configuration register file, write only, unknown indexes are dropped
// ----------------------------------------------------------------------------
module bdlp_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bdlp_pkg::MsW-1:0]    cfg_data_i,
  output bdlp_pkg::cfg_t              cfg_o
);
  import bdlp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DEBOUNCE_RST;
      cfg_q.long_press_ms <= LONG_PRESS_RST;
      cfg_q.last_page     <= LAST_PAGE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data_i;
        CFG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data_i;
        CFG_LAST_PAGE:  cfg_q.last_page     <= cfg_data_i[PageW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/bdlp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_engine
// debounce and press-length state, updated once per word that moves on
// ----------------------------------------------------------------------------
module bdlp_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bdlp_pkg::cfg_t             cfg_i,
  input  logic                       step_i,
  input  logic [bdlp_pkg::TimeW-1:0] now_ms_i,
  input  logic                       raw_level_i,
  output bdlp_pkg::res_t             res_o
);
  import bdlp_pkg::*;

  logic             prev_raw_q, prev_raw_d;
  logic             debounced_q, debounced_d;
  logic [TimeW-1:0] change_time_q, change_time_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic             long_seen_q, long_seen_d;
  logic [PageW-1:0] page_q, page_d;
  logic             portrait_q, portrait_d;

  logic             raw_changed;
  logic [TimeW-1:0] settle_diff;
  logic [TimeW-1:0] held_diff;
  logic             settled;
  logic             press_edge;
  logic             release_edge;
  logic             long_hit;
  logic             stepped;
  logic             turned;

  always_comb begin
    raw_changed   = (raw_level_i != prev_raw_q);
    prev_raw_d    = raw_level_i;
    change_time_d = raw_changed ? now_ms_i : change_time_q;
    settle_diff   = now_ms_i - change_time_d;
    settled       = (settle_diff >= {{(TimeW-MsW){1'b0}}, cfg_i.debounce_ms});

    press_edge   = settled && (raw_level_i != debounced_q) && !raw_level_i;
    release_edge = settled && (raw_level_i != debounced_q) && raw_level_i;

    // a fresh press is timed from now, so only a zero long time hits at once
    // once settled the new debounced level is the raw level, so a release
    // in this word never counts as a long hold
    held_diff = now_ms_i - press_time_q;
    if (press_edge) begin
      long_hit = (cfg_i.long_press_ms == '0);
    end else begin
      long_hit = settled && !raw_level_i && !long_seen_q &&
                 (held_diff >= {{(TimeW-MsW){1'b0}}, cfg_i.long_press_ms});
    end

    debounced_d  = settled ? raw_level_i : debounced_q;
    press_time_d = press_edge ? now_ms_i : press_time_q;
    stepped      = release_edge && !long_seen_q;
    turned       = long_hit;

    long_seen_d = long_seen_q;
    if (press_edge) begin
      long_seen_d = 1'b0;
    end
    if (long_hit) begin
      long_seen_d = 1'b1;
    end

    page_d = page_q;
    if (stepped) begin
      page_d = (page_q >= cfg_i.last_page) ? '0 : page_q + PageW'(1);
    end
    portrait_d = portrait_q ^ turned;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q    <= 1'b1;
      debounced_q   <= 1'b1;
      change_time_q <= '0;
      press_time_q  <= '0;
      long_seen_q   <= 1'b0;
      page_q        <= '0;
      portrait_q    <= 1'b0;
    end else if (step_i) begin
      prev_raw_q    <= prev_raw_d;
      debounced_q   <= debounced_d;
      change_time_q <= change_time_d;
      press_time_q  <= press_time_d;
      long_seen_q   <= long_seen_d;
      page_q        <= page_d;
      portrait_q    <= portrait_d;
    end
  end

  always_comb begin
    res_o.stable_level  = debounced_d;
    res_o.page          = page_d;
    res_o.portrait_mode = portrait_d;
    res_o.page_stepped  = stepped;
    res_o.rotated       = turned;
  end

endmodule

### rtl/button_debounce_long_press_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// debouncer for an active-low button with short and long press detection
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   now_ms_i, raw_level_i
//  out      source     out_valid_o / out_stall_i stable_level_o, page_o,
//                                                portrait_mode_o,
//                                                page_stepped_o, rotated_o
//  cfg      sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  one word in, one word out; a word passes the input register, then the result
//  register, and a new word is taken each cycle unless in_stall_o is high;
//  the rate is set by the state update in the engine
//  reset gives the released button, page 0, landscape and default registers
//  a stall on the output holds the result register; the input register
//  then fills and in_stall_o rises only once both are occupied
//
module button_debounce_long_press_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bdlp_pkg::MsW-1:0]    cfg_data_i,
  // sample words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bdlp_pkg::TimeW-1:0]  now_ms_i,
  input  logic                        raw_level_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        stable_level_o,
  output logic [bdlp_pkg::PageW-1:0]  page_o,
  output logic                        portrait_mode_o,
  output logic                        page_stepped_o,
  output logic                        rotated_o
);
  import bdlp_pkg::*;

  cfg_t             cfg;
  res_t             res;

  // input register
  logic             in_valid_q;
  logic [TimeW-1:0] now_q;
  logic             raw_q;

  // result register
  logic             out_valid_q;
  res_t             res_q;

  logic             out_free;  // result register can take a word
  logic             advance;   // word moves from input to result register
  logic             in_take;   // input register takes a new word

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  bdlp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // state commits only when the word leaves for the result register
  bdlp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .now_ms_i    (now_q),
    .raw_level_i (raw_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q <= now_ms_i;
      raw_q <= raw_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stable_level_o  = res_q.stable_level;
  assign page_o          = res_q.page;
  assign portrait_mode_o = res_q.portrait_mode;
  assign page_stepped_o  = res_q.page_stepped;
  assign rotated_o       = res_q.rotated;

endmodule
